/* src/tcw_pkg.sv */
package tcw_pkg;

  localparam int COLS_DEF        = 80;
  localparam int ROWS_DEF        = 25;
  localparam int QUEUE_DEPTH_DEF = 4;

  localparam int MODE_W     = 2;
  localparam int CHAR_W     = 8;
  localparam int RADDR_W    = 11;
  localparam int ROW_OUT_W  = 5;
  localparam int COL_OUT_W  = 7;
  localparam int POS_OUT_W  = 11;
  localparam int CELL_W     = 16;
  // wide enough for any cell address in the supported geometry range
  localparam int ADDR_MAX_W = 16;

  localparam logic [MODE_W-1:0] MODE_PUT   = 2'd0;
  localparam logic [MODE_W-1:0] MODE_CLEAR = 2'd1;
  localparam logic [MODE_W-1:0] MODE_READ  = 2'd2;

  localparam logic [CHAR_W-1:0] CH_NEWLINE   = 8'h0A;
  localparam logic [CHAR_W-1:0] CH_RETURN    = 8'h0D;
  localparam logic [CHAR_W-1:0] CH_BACKSPACE = 8'h08;
  localparam logic [CHAR_W-1:0] CH_SPACE     = 8'h20;
  localparam logic [CHAR_W-1:0] ATTR         = 8'h07;
  localparam logic [CELL_W-1:0] CELL_BLANK   = {ATTR, CH_SPACE};

  typedef enum logic [2:0] {
    OP_NONE,
    OP_WRITE,
    OP_READ,
    OP_SCROLL,
    OP_CLEAR
  } op_t;

  typedef struct packed {
    op_t                   op;
    logic [ADDR_MAX_W-1:0] addr;
    logic [CHAR_W-1:0]     char_code;
    logic [ROW_OUT_W-1:0]  row;
    logic [COL_OUT_W-1:0]  col;
    logic [POS_OUT_W-1:0]  pos;
  } cmd_t;

endpackage

/* src/text_console_writer.sv */
// Text console writer: a COLS x ROWS screen of 16-bit cells (attribute 0x07,
// character in the low byte) with a cursor.
// Input channel in_valid/in_ready carries mode, char_code and read_address;
// output channel out_valid/out_ready returns one transaction per input with
// the cursor after the item and, for a read, the addressed cell.
// The front end updates the cursor and queues a memory command; the back end
// runs the commands against a single-port-write, single-port-read cell RAM.
// Put, read and no-op items go from the queue through the idle and finish
// states to the out_valid register; the next command is taken only after
// finish. A newline on the bottom row (scroll) or a clear walks every RAM
// cell, with the queue of QUEUE_DEPTH commands absorbing input meanwhile.
// Reset: the cursor homes and a clearing pass blanks the RAM; in_ready stays
// low until it ends.
// A stalled receiver holds the result in the output register; the back end
// then stops, the queue fills and in_ready drops.
module text_console_writer import tcw_pkg::*; #(
  parameter int COLS        = COLS_DEF,
  parameter int ROWS        = ROWS_DEF,
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [MODE_W-1:0]    mode,
  input  logic [CHAR_W-1:0]    char_code,
  input  logic [RADDR_W-1:0]   read_address,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [ROW_OUT_W-1:0] cursor_row,
  output logic [COL_OUT_W-1:0] cursor_col,
  output logic [POS_OUT_W-1:0] cursor_position,
  output logic [CELL_W-1:0]    cell_data
);

  logic q_push;
  logic q_pop;
  logic q_full;
  logic q_empty;
  cmd_t q_wdata;
  cmd_t q_rdata;
  logic init_busy;

  tcw_front #(
    .COLS (COLS),
    .ROWS (ROWS)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .mode         (mode),
    .char_code    (char_code),
    .read_address (read_address),
    .init_busy    (init_busy),
    .q_full       (q_full),
    .q_push       (q_push),
    .q_data       (q_wdata)
  );

  tcw_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (q_wdata),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (q_rdata),
    .empty     (q_empty)
  );

  tcw_back #(
    .COLS (COLS),
    .ROWS (ROWS)
  ) u_back (
    .clk             (clk),
    .rst             (rst),
    .q_empty         (q_empty),
    .q_data          (q_rdata),
    .q_pop           (q_pop),
    .init_busy       (init_busy),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .cursor_row      (cursor_row),
    .cursor_col      (cursor_col),
    .cursor_position (cursor_position),
    .cell_data       (cell_data)
  );

`ifndef SYNTHESIS
  a_no_push_when_full: assert property (@(posedge clk) disable iff (rst)
    q_push |-> !q_full)
    else $error("command pushed into full queue");

  a_no_pop_when_empty: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> !q_empty)
    else $error("command popped from empty queue");

  a_accept_queues: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !q_empty)
    else $error("accepted transaction missing from queue");
`endif

endmodule

/* src/tcw_queue.sv */
module tcw_queue import tcw_pkg::*; #(
  parameter int DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  cmd_t push_data,
  output logic full,
  input  logic pop,
  output cmd_t pop_data,
  output logic empty
);

  localparam int IDX_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  cmd_t             entries [DEPTH];
  logic [IDX_W-1:0] wr_ptr;
  logic [IDX_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full     = (count == CNT_W'(DEPTH));
  assign empty    = (count == '0);
  assign pop_data = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == IDX_W'(DEPTH - 1)) ? '0 : wr_ptr + IDX_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == IDX_W'(DEPTH - 1)) ? '0 : rd_ptr + IDX_W'(1);
      end
      if (push && !pop) begin
        count <= count + CNT_W'(1);
      end else if (pop && !push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

endmodule

/* src/tcw_front.sv */
module tcw_front import tcw_pkg::*; #(
  parameter int COLS = COLS_DEF,
  parameter int ROWS = ROWS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [MODE_W-1:0]  mode,
  input  logic [CHAR_W-1:0]  char_code,
  input  logic [RADDR_W-1:0] read_address,
  input  logic               init_busy,
  input  logic               q_full,
  output logic               q_push,
  output cmd_t               q_data
);

  localparam int CELL_COUNT    = COLS * ROWS;
  localparam int ROW_W         = $clog2(ROWS);
  localparam int COL_W         = $clog2(COLS);
  localparam int ADDR_W        = $clog2(CELL_COUNT);
  localparam int LAST_ROW_BASE = (ROWS - 1) * COLS;

  logic [ROW_W-1:0]  row;
  logic [COL_W-1:0]  col;
  logic [ADDR_W-1:0] pos;
  logic [ROW_W-1:0]  row_next;
  logic [COL_W-1:0]  col_next;
  logic [ADDR_W-1:0] pos_next;
  op_t               op;
  logic [ADDR_W-1:0] addr;
  logic [CHAR_W-1:0] ch;
  logic              bottom;

  assign in_ready = !q_full && !init_busy;
  assign q_push   = in_valid && in_ready;
  assign bottom   = (row == ROW_W'(ROWS - 1));

  always_comb begin
    row_next = row;
    col_next = col;
    pos_next = pos;
    op       = OP_NONE;
    addr     = '0;
    ch       = char_code;
    case (mode)
      MODE_PUT: begin
        case (char_code)
          CH_NEWLINE: begin
            col_next = '0;
            if (bottom) begin
              op       = OP_SCROLL;
              pos_next = ADDR_W'(LAST_ROW_BASE);
            end else begin
              row_next = row + ROW_W'(1);
              pos_next = pos - ADDR_W'(col) + ADDR_W'(COLS);
            end
          end
          CH_RETURN: begin
            col_next = '0;
            pos_next = pos - ADDR_W'(col);
          end
          CH_BACKSPACE: begin
            if (col != '0) begin
              col_next = col - COL_W'(1);
              pos_next = pos - ADDR_W'(1);
              op       = OP_WRITE;
              addr     = pos - ADDR_W'(1);
              ch       = CH_SPACE;
            end
          end
          default: begin
            op   = OP_WRITE;
            addr = pos;
            if (col == COL_W'(COLS - 1)) begin
              col_next = '0;
              if (bottom) begin
                pos_next = pos - ADDR_W'(COLS - 1);
              end else begin
                row_next = row + ROW_W'(1);
                pos_next = pos + ADDR_W'(1);
              end
            end else begin
              col_next = col + COL_W'(1);
              pos_next = pos + ADDR_W'(1);
            end
          end
        endcase
      end
      MODE_CLEAR: begin
        op       = OP_CLEAR;
        row_next = '0;
        col_next = '0;
        pos_next = '0;
      end
      MODE_READ: begin
        if (32'(read_address) < CELL_COUNT) begin
          op   = OP_READ;
          addr = ADDR_W'(read_address);
        end
      end
      default: begin
        op = OP_NONE;
      end
    endcase
  end

  always_comb begin
    q_data.op        = op;
    q_data.addr      = ADDR_MAX_W'(addr);
    q_data.char_code = ch;
    q_data.row       = ROW_OUT_W'(row_next);
    q_data.col       = COL_OUT_W'(col_next);
    q_data.pos       = POS_OUT_W'(pos_next);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row <= '0;
      col <= '0;
      pos <= '0;
    end else if (q_push) begin
      row <= row_next;
      col <= col_next;
      pos <= pos_next;
    end
  end

endmodule

/* src/tcw_back.sv */
module tcw_back import tcw_pkg::*; #(
  parameter int COLS = COLS_DEF,
  parameter int ROWS = ROWS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 q_empty,
  input  cmd_t                 q_data,
  output logic                 q_pop,
  output logic                 init_busy,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [ROW_OUT_W-1:0] cursor_row,
  output logic [COL_OUT_W-1:0] cursor_col,
  output logic [POS_OUT_W-1:0] cursor_position,
  output logic [CELL_W-1:0]    cell_data
);

  localparam int CELL_COUNT = COLS * ROWS;
  localparam int ADDR_W     = $clog2(CELL_COUNT);
  localparam int COPY_END   = CELL_COUNT - COLS;
  localparam int LAST_CELL  = CELL_COUNT - 1;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SWEEP,
    S_FINISH
  } state_t;

  logic [CELL_W-1:0] cells [CELL_COUNT];

  state_t            state;
  cmd_t              cmd;
  logic [ADDR_W-1:0] idx;
  logic              scroll;
  logic              pw_valid;
  logic              pw_copy;
  logic [ADDR_W-1:0] pw_addr;
  logic [CELL_W-1:0] pw_data;
  logic [CELL_W-1:0] rdata;
  logic              rd_en;
  logic [ADDR_W-1:0] rd_addr;
  logic              copy_now;
  logic [CELL_W-1:0] wr_data;

  assign q_pop    = (state == S_IDLE) && !q_empty;
  assign copy_now = scroll && (32'(idx) < COPY_END);
  assign wr_data  = pw_copy ? rdata : pw_data;

  always_comb begin
    rd_en   = 1'b0;
    rd_addr = '0;
    if (q_pop && q_data.op == OP_READ) begin
      rd_en   = 1'b1;
      rd_addr = q_data.addr[ADDR_W-1:0];
    end else if (state == S_SWEEP && copy_now) begin
      rd_en   = 1'b1;
      rd_addr = idx + ADDR_W'(COLS);
    end
  end

  // writes go through the pw_ registers so a scroll copy can take the registered read data
  always_ff @(posedge clk) begin
    if (pw_valid) begin
      cells[pw_addr] <= wr_data;
    end
    if (rd_en) begin
      rdata <= cells[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_SWEEP;
      init_busy <= 1'b1;
      scroll    <= 1'b0;
      idx       <= '0;
      pw_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      pw_valid <= 1'b0;
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (!q_empty) begin
            cmd <= q_data;
            idx <= '0;
            case (q_data.op)
              OP_WRITE: begin
                pw_valid <= 1'b1;
                pw_copy  <= 1'b0;
                pw_addr  <= q_data.addr[ADDR_W-1:0];
                pw_data  <= {ATTR, q_data.char_code};
                state    <= S_FINISH;
              end
              OP_SCROLL: begin
                scroll <= 1'b1;
                state  <= S_SWEEP;
              end
              OP_CLEAR: begin
                scroll <= 1'b0;
                state  <= S_SWEEP;
              end
              default: begin
                state <= S_FINISH;
              end
            endcase
          end
        end
        S_SWEEP: begin
          pw_valid <= 1'b1;
          pw_copy  <= copy_now;
          pw_addr  <= idx;
          pw_data  <= CELL_BLANK;
          idx      <= idx + ADDR_W'(1);
          if (32'(idx) == LAST_CELL) begin
            state <= S_FINISH;
          end
        end
        S_FINISH: begin
          if (init_busy) begin
            init_busy <= 1'b0;
            state     <= S_IDLE;
          end else if (!out_valid || out_ready) begin
            out_valid       <= 1'b1;
            cursor_row      <= cmd.row;
            cursor_col      <= cmd.col;
            cursor_position <= cmd.pos;
            cell_data       <= (cmd.op == OP_READ) ? rdata : '0;
            state           <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule
